### rtl/mlcc_pkg.sv
package mlcc_pkg;

   // field widths of one word on the request and response channels
   localparam int unsigned ADDR_W = 12;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned CRC_W  = 32;
   localparam int unsigned PFX_W  = 16;

   // reflected crc-32 polynomial and record constants
   localparam logic [CRC_W-1:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_INVERT    = 32'hFFFF_FFFF;
   localparam logic [PFX_W-1:0] IMEM_SELECT   = 16'h8000;

   // command codes
   typedef enum logic {
      CMD_MEM_WRITE = 1'b0,
      CMD_CSR_WRITE = 1'b1
   } cmd_type;

   // one request word as held in the input register
   typedef struct packed {
      cmd_type           command;
      logic              is_imem;
      logic [ADDR_W-1:0] byte_address;
      logic [DATA_W-1:0] data_word;
   } req_item_type;

   // advance the internal (non-inverted) crc state by one byte, lsb first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0]       data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-8){1'b0}}, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/mlcc_if.sv
// request channel: observed memory writes and checksum register writes
interface mlcc_req_if;
   import mlcc_pkg::*;

   logic              valid;
   logic              ready;
   cmd_type           command;
   logic              is_imem;
   logic [ADDR_W-1:0] byte_address;
   logic [DATA_W-1:0] data_word;

   modport source (output valid, output command, output is_imem, output byte_address,
                   output data_word, input ready);
   modport sink   (input valid, input command, input is_imem, input byte_address,
                   input data_word, output ready);
endinterface

// response channel: checksum value after each request word
interface mlcc_rsp_if;
   import mlcc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] checksum_value;

   modport source (output valid, output checksum_value, input ready);
   modport sink   (input valid, input checksum_value, output ready);
endinterface

### rtl/mlcc_update.sv
module mlcc_update #(
   parameter int unsigned INDEX_BITS = 9
) (
   input  mlcc_pkg::req_item_type    item,
   input  logic [mlcc_pkg::CRC_W-1:0] finished_crc,
   output logic [mlcc_pkg::CRC_W-1:0] next_crc
);
   import mlcc_pkg::*;

   // index bits that the 12-bit address can actually supply
   localparam int unsigned IDX_W = (INDEX_BITS < ADDR_W - 2) ? INDEX_BITS : ADDR_W - 2;

   logic [PFX_W-1:0] prefix;
   logic [CRC_W-1:0] crc;

   // 16-bit prefix: memory select on top, word index at the bottom
   always_comb begin
      prefix = PFX_W'(item.byte_address[IDX_W+1:2]);
      if (item.is_imem) begin
         prefix = prefix | IMEM_SELECT;
      end
   end

   // fold the 48-bit record into the crc, or take the register write
   always_comb begin
      crc = finished_crc ^ CRC_INVERT;
      for (int k = 0; k < DATA_W / 8; k++) begin
         crc = crc_byte(crc, item.data_word[8*k +: 8]);
      end
      crc = crc_byte(crc, prefix[7:0]);
      crc = crc_byte(crc, prefix[15:8]);

      unique case (item.command)
         CMD_CSR_WRITE: next_crc = item.data_word;
         CMD_MEM_WRITE: next_crc = crc ^ CRC_INVERT;
         default:       next_crc = crc ^ CRC_INVERT;
      endcase
   end

endmodule

### rtl/memory_load_crc_checksum.sv
// Load-integrity checksum unit.
// req channel: one word per observed 32-bit memory write (command 0) or per
// software write of the checksum register (command 1). A memory write folds
// a 48-bit record (data word, then 16-bit prefix of memory select and word
// index) into a running reflected crc-32; a register write loads the value.
// rsp channel: one word per request word, carrying the checksum register
// value right after that request took effect.
// Order: an accepted word is held in the input register, then folded into the
// checksum register, which raises its response; a held response stalls the fold.
// Throughput: one word per cycle while the response is not held. The input register and the checksum
// register are separated by the 48-bit crc update network, which sets the
// cycle time.
// Stall: while rsp is held, the checksum register and the response hold; the
// input register still takes one more word, after which req_ready drops.
// Reset (synchronous): the checksum register clears to zero, both stages
// empty, and req_ready is low during reset.
module memory_load_crc_checksum #(
   parameter int unsigned INDEX_BITS = 9
) (
   input  logic            clock,
   input  logic            reset,
   mlcc_req_if.sink        req_if,
   mlcc_rsp_if.source      rsp_if
);
   import mlcc_pkg::*;

   req_item_type     item_ff;
   req_item_type     item_in;
   logic             item_valid_ff;
   logic             item_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic [CRC_W-1:0] next_crc;
   logic             advance;
   logic             req_take;

   // handshake control
   assign advance  = item_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !reset && (!item_valid_ff || advance);

   // next values of the two stages
   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.command      = req_if.command;
         item_in.is_imem      = req_if.is_imem;
         item_in.byte_address = req_if.byte_address;
         item_in.data_word    = req_if.data_word;
      end
      item_valid_in = req_take || (item_valid_ff && !advance);
      rsp_valid_in  = advance || (rsp_valid_ff && !rsp_if.ready);
      crc_in        = advance ? next_crc : crc_ff;
   end

   // checksum update network
   mlcc_update #(
      .INDEX_BITS (INDEX_BITS)
   ) u_update (
      .item         (item_ff),
      .finished_crc (crc_ff),
      .next_crc     (next_crc)
   );

   // input register payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // control and checksum register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         crc_ff        <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         crc_ff        <= crc_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.checksum_value = crc_ff;

endmodule

### rtl/mlcc_checker.sv
module mlcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_checksum
);

   // no response word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request side is closed during reset
   a_reset_closed: assert property (@(posedge clock) reset |-> !req_ready)
      else $error("request ready during reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum))
      else $error("stalled response word changed");

   // with the request side ready but idle last cycle, a delivered word is not followed by another
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && $past(req_ready && !req_valid) |=> !rsp_valid)
      else $error("response word without a request word");

endmodule

bind memory_load_crc_checksum mlcc_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_checksum (rsp_if.checksum_value)
);
